@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the stack bank checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define MSB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define MSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/msb_pkg.sv @@
// ----------------------------------------------------------------------------
// msb_pkg
// shared types, codes and widths for the multiple stack bank
// ----------------------------------------------------------------------------
package msb_pkg;

    localparam int DEF_NUM_STACKS  = 16;
    localparam int DEF_STACK_DEPTH = 256;

    localparam int KIND_W      = 2;
    localparam int SID_W       = 4;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        OP_PUSH = 2'd0,
        OP_TOP  = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_KIND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } msb_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } msb_stat_t;

endpackage

@@ rtl/msb_ctrl.sv @@
// ----------------------------------------------------------------------------
// msb_ctrl
// sequencer: capture a word, execute it on the store, hand off the result
// ----------------------------------------------------------------------------
module msb_ctrl
    import msb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  msb_stat_t stat,
    output logic      s_tready,
    output msb_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (stat.in_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == S_IDLE);
        cmd.capture = (state_reg == S_IDLE) && stat.in_valid;
        cmd.exec    = (state_reg == S_EXEC);
        cmd.load    = (state_reg == S_OUT) && stat.out_free;
    end

endmodule

@@ rtl/msb_datapath.sv @@
// ----------------------------------------------------------------------------
// msb_datapath
// fill counters, shared entry memory and the result register
// ----------------------------------------------------------------------------
module msb_datapath
    import msb_pkg::*;
#(
    parameter int NUM_STACKS  = DEF_NUM_STACKS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    // kind, stack_id, push_value
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    // status, top_value
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  msb_cmd_t               cmd,
    output msb_stat_t              stat
);

    localparam int IDX_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W     = $clog2(STACK_DEPTH);
    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PAD_W     = OUT_TDATA_W - STATUS_W - VAL_W;

    logic [KIND_W-1:0]   kind_reg;
    logic [SID_W-1:0]    sid_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [FILL_W-1:0]   fill_reg [NUM_STACKS];
    logic [VAL_W-1:0]    mem_reg [MEM_DEPTH];
    logic [VAL_W-1:0]    rd_data_reg;
    status_t             status_reg;
    logic                is_top_reg;
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [VAL_W-1:0]    m_value_reg;

    logic                known;
    logic [IDX_W-1:0]    idx;
    logic [FILL_W-1:0]   fill_cur;
    logic [FILL_W-1:0]   fill_dec;
    logic                is_empty;
    logic                is_full;
    logic                push_ok;
    logic                top_ok;
    logic                pop_ok;
    status_t             status_next;
    logic [PTR_W-1:0]    ptr;
    logic [ADDR_W-1:0]   addr;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_tdata[KIND_W-1:0];
            sid_reg  <= s_tdata[KIND_W+SID_W-1:KIND_W];
            val_reg  <= s_tdata[KIND_W+SID_W+VAL_W-1:KIND_W+SID_W];
        end
    end

    always_comb begin
        known    = (32'(sid_reg) < 32'(NUM_STACKS));
        idx      = IDX_W'(sid_reg);
        fill_cur = known ? fill_reg[idx] : '0;
        fill_dec = fill_cur - FILL_W'(1);
        is_empty = (fill_cur == '0);
        is_full  = (fill_cur == FILL_W'(STACK_DEPTH));
        push_ok  = 1'b0;
        top_ok   = 1'b0;
        pop_ok   = 1'b0;
        unique case (kind_reg)
            OP_PUSH: begin
                push_ok     = known && !is_full;
                status_next = push_ok ? ST_DONE : ST_FULL;
            end
            OP_TOP: begin
                top_ok      = known && !is_empty;
                status_next = top_ok ? ST_DONE : ST_EMPTY;
            end
            OP_POP: begin
                pop_ok      = known && !is_empty;
                status_next = pop_ok ? ST_DONE : ST_EMPTY;
            end
            default: begin
                status_next = ST_BAD_KIND;
            end
        endcase
        ptr  = push_ok ? fill_cur[PTR_W-1:0] : fill_dec[PTR_W-1:0];
        addr = ADDR_W'(ADDR_W'(idx) * ADDR_W'(STACK_DEPTH)) + ADDR_W'(ptr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            if (push_ok) begin
                fill_reg[idx] <= fill_cur + FILL_W'(1);
            end else if (pop_ok) begin
                fill_reg[idx] <= fill_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && push_ok) begin
            mem_reg[addr] <= val_reg;
        end
        if (cmd.exec && top_ok) begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            is_top_reg <= (kind_reg == OP_TOP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_status_reg <= status_reg;
            m_value_reg  <= (status_reg == ST_DONE && is_top_reg) ? rd_data_reg : '0;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = {{PAD_W{1'b0}}, m_value_reg, m_status_reg};
    assign stat.in_valid = s_tvalid;
    assign stat.out_free = !m_valid_reg || m_tready;

endmodule

@@ rtl/multi_stack_bank_unit.sv @@
// ----------------------------------------------------------------------------
// multi_stack_bank_unit
// bank of lifo stacks in one shared memory, one status word per input word
// sequence per word: capture, memory access, load into the output register
// the load waits while the output is stalled, and s_tready stays low until it is done
// the memory read for top is registered in the memory access step
// reset: aresetn synchronous active low, empties every stack, memory not cleared
// ----------------------------------------------------------------------------
module multi_stack_bank_unit
    import msb_pkg::*;
#(
    parameter int NUM_STACKS  = DEF_NUM_STACKS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // kind [1:0], stack_id [5:2], push_value [37:6], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status [1:0], top_value [33:2], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    msb_cmd_t  cmd;
    msb_stat_t stat;

    msb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    msb_datapath #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

@@ rtl/msb_checker.sv @@
// ----------------------------------------------------------------------------
// msb_checker
// port level checks for the stack bank, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_checker
    import msb_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic                stalled;
    logic                take_in;
    logic                out_failed;
    logic [STATUS_W-1:0] out_status;
    logic [VAL_W-1:0]    out_value;

    assign stalled    = m_tvalid && !m_tready;
    assign take_in    = s_tvalid && s_tready;
    assign out_status = m_tdata[STATUS_W-1:0];
    assign out_value  = m_tdata[STATUS_W+VAL_W-1:STATUS_W];
    assign out_failed = m_tvalid && (out_status != ST_DONE);

    `MSB_ASSERT(a_out_hold, aclk, aresetn, stalled |=> m_tvalid && $stable(m_tdata), "word not held")
    `MSB_ASSERT(a_one_in_flight, aclk, aresetn, take_in |=> !s_tready, "second word taken")
    `MSB_ASSERT(a_value_zero, aclk, aresetn, out_failed |-> out_value == '0, "value not zero")
    `MSB_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid && s_tready, "not idle after reset")

endmodule

bind multi_stack_bank_unit msb_checker u_msb_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives push, top, pop and bad kind words into the stack bank through the
// input stream, predicts every status word with a local copy of the stacks
// and compares each returned word field by field, under three stall patterns
// ----------------------------------------------------------------------------
module tb_top;
    import msb_pkg::*;

    localparam int NSTK        = DEF_NUM_STACKS;
    localparam int DEPTH       = DEF_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 415;
    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

    typedef struct {
        status_t          status;
        logic [VAL_W-1:0] top_value;
    } stack_result_t;

    class stack_bank_scoreboard;
        int unsigned      fill [NSTK];
        logic [VAL_W-1:0] entries [NSTK][DEPTH];
        stack_result_t    pending [$];
        int errors;
        int n_words, n_push, n_top, n_pop, n_empty, n_full, n_bad;

        function new();
            foreach (fill[i]) fill[i] = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void note_word(logic [KIND_W-1:0] kind, logic [SID_W-1:0] sid,
                                logic [VAL_W-1:0] val);
            stack_result_t r;
            bit known;
            r.status    = ST_DONE;
            r.top_value = '0;
            known       = (sid < NSTK);
            n_words++;
            if (kind == OP_PUSH) begin
                if (!known || fill[sid] >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    entries[sid][fill[sid]] = val;
                    fill[sid]++;
                    n_push++;
                end
            end else if (kind == OP_TOP) begin
                if (!known || fill[sid] == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    r.top_value = entries[sid][fill[sid] - 1];
                    n_top++;
                end
            end else if (kind == OP_POP) begin
                if (!known || fill[sid] == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    fill[sid]--;
                    n_pop++;
                end
            end else begin
                r.status = ST_BAD_KIND;
                n_bad++;
            end
            pending.push_back(r);
        endfunction

        task check_word(logic [OUT_TDATA_W-1:0] word);
            stack_result_t    want;
            status_t          got_status;
            logic [VAL_W-1:0] got_value;
            got_status = status_t'(word[STATUS_W-1:0]);
            got_value  = word[STATUS_W+VAL_W-1:STATUS_W];
            if (pending.size() == 0) begin
                report($sformatf("status word %h with nothing outstanding", word));
            end else begin
                want = pending.pop_front();
                if (got_status !== want.status)
                    report($sformatf("status %0d, predicted %0d",
                                     got_status, want.status));
                if (got_value !== want.top_value)
                    report($sformatf("top_value %h, predicted %h",
                                     got_value, want.top_value));
            end
        endtask

        function void summary();
            $display("run covered %0d words: %0d push, %0d top, %0d pop done",
                     n_words, n_push, n_top, n_pop);
            $display("empty stack hits %0d, full stack drops %0d, bad kinds %0d",
                     n_empty, n_full, n_bad);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    stack_bank_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;

    multi_stack_bank_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d words sent", CYCLE_LIMIT, words_sent);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [VAL_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return 32'h8000_0000;
        if (pick < 6) return 32'h7FFF_FFFF;
        if (pick < 8) return 32'h0000_0000;
        if (pick < 10) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SID_W-1:0] sid,
                             input logic [VAL_W-1:0] val);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = IN_TDATA_W'({$urandom, $urandom});
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, val, sid, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(kind, sid, val);
        words_sent++;
    endtask

    task automatic run_directed();
        send_word(OP_TOP,   4'd0,  32'h1234_5678);
        send_word(OP_POP,   4'd0,  32'h0);
        send_word(OP_PUSH,  4'd0,  32'h7FFF_FFFF);
        send_word(OP_TOP,   4'd0,  32'h0);
        send_word(OP_PUSH,  4'd0,  32'h8000_0000);
        send_word(OP_TOP,   4'd0,  32'h0);
        send_word(OP_PUSH,  4'd15, 32'hFFFF_FFFF);
        send_word(OP_PUSH,  4'd15, 32'h0000_0000);
        send_word(OP_TOP,   4'd15, 32'hFFFF_FFFF);
        send_word(OP_POP,   4'd15, 32'h0);
        send_word(OP_TOP,   4'd15, 32'h0);
        send_word(KIND_BAD, 4'd3,  32'hA5A5_A5A5);
        send_word(KIND_BAD, 4'd15, 32'hFFFF_FFFF);
        send_word(OP_POP,   4'd0,  32'h0);
        send_word(OP_TOP,   4'd0,  32'h0);
        send_word(OP_POP,   4'd0,  32'h0);
        send_word(OP_POP,   4'd0,  32'h0);
        send_word(OP_TOP,   4'd0,  32'h0);
        send_word(OP_PUSH,  4'd10, 32'h5555_5555);
        send_word(OP_PUSH,  4'd5,  32'hAAAA_AAAA);
        send_word(OP_TOP,   4'd10, 32'h0);
        send_word(OP_TOP,   4'd5,  32'h0);
        send_word(OP_POP,   4'd5,  32'h0);
        send_word(OP_POP,   4'd10, 32'h0);
        send_word(OP_TOP,   4'd15, 32'h0);
    endtask

    // push until full, overflow twice, then back off a little
    task automatic fill_stack(input logic [SID_W-1:0] sid);
        int n;
        while (sb.fill[sid] < DEPTH) send_word(OP_PUSH, sid, rand_value());
        send_word(OP_PUSH, sid, rand_value());
        send_word(OP_TOP, sid, $urandom);
        send_word(OP_PUSH, sid, rand_value());
        n = $urandom_range(1, 16);
        repeat (n) begin
            send_word(OP_POP, sid, $urandom);
            if ($urandom_range(0, 1)) send_word(OP_TOP, sid, $urandom);
        end
    endtask

    task automatic drain_stack(input logic [SID_W-1:0] sid);
        int n;
        n = sb.fill[sid];
        if (n > 48) n = 48;
        repeat (n + 2) begin
            send_word(OP_POP, sid, $urandom);
            if ($urandom_range(0, 3) == 0) send_word(OP_TOP, sid, $urandom);
        end
    endtask

    task automatic mixed_burst(input int len);
        logic [SID_W-1:0]  hot [3];
        logic [SID_W-1:0]  sid;
        logic [KIND_W-1:0] kind;
        int pick;
        foreach (hot[i]) hot[i] = SID_W'($urandom_range(0, NSTK - 1));
        repeat (len) begin
            if ($urandom_range(0, 99) < 70) sid = hot[$urandom_range(0, 2)];
            else sid = SID_W'($urandom_range(0, NSTK - 1));
            pick = $urandom_range(0, 99);
            if (pick < 42) kind = OP_PUSH;
            else if (pick < 67) kind = OP_TOP;
            else if (pick < 95) kind = OP_POP;
            else kind = KIND_BAD;
            send_word(kind, sid, rand_value());
        end
    endtask

    task automatic run_phase(input int target);
        int  start;
        int  pick;
        bit  filled;
        start  = words_sent;
        filled = 1'b0;
        while (words_sent - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 10 && !filled) begin
                fill_stack(SID_W'($urandom_range(0, NSTK - 1)));
                filled = 1'b1;
            end else if (pick < 20) begin
                drain_stack(SID_W'($urandom_range(0, NSTK - 1)));
            end else begin
                mixed_burst($urandom_range(8, 24));
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 33;
        recv_idle_pct = 69;
        words_sent    = 0;
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();
        run_phase(PHASE_WORDS);
        send_idle_pct = 69;
        recv_idle_pct = 33;
        run_phase(PHASE_WORDS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(PHASE_WORDS);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        sb.summary();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
